>>> src/hsl_pkg.sv
`default_nettype none
package hsl_pkg;

  // Input scale: 4096 is one, for saturation and lightness alike.
  localparam int unsigned UNIT_IN    = 4096;
  // Hue in 1/16 degree: a full turn and one 60-degree sector.
  localparam int unsigned HUE_FULL   = 5760;
  localparam int unsigned HUE_SECTOR = 960;
  // Six full turns lift every 16-bit hue to a positive value.
  localparam int unsigned HUE_BIAS   = 6 * HUE_FULL;
  // ceil(2^16 / 15): exact quotient by 15 for operands below 4681.
  localparam int unsigned HUE_DIV15_RECIP = 4370;
  // ceil(2^8 / 6): exact quotient by 6 for operands below 128.
  localparam int unsigned SEC_DIV6_RECIP  = 43;
  localparam int unsigned BYTE_MAX = 255;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage
`default_nettype wire

>>> src/hsl_to_rgb_converter.sv
// An accepted word passes the registers of stages 1 to 6; stage 6 drives out_valid.
// Throughput: one word per cycle; busy is held low, as every stage advances in
// every cycle and the receiver cannot stall. The rate is set by the six-stage
// pipeline, whose widest step is the reciprocal multiply that divides by 15.
// Reset (rst_n low, synchronous) clears the valid bits of all stages.
`default_nettype none
module hsl_to_rgb_converter
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_hue,
  input  wire logic signed [13:0] in_saturation,
  input  wire logic signed [13:0] in_lightness,
  output logic                    out_valid,
  output logic             [7:0]  out_red,
  output logic             [7:0]  out_green,
  output logic             [7:0]  out_blue
);

  localparam int CW        = FRAC_BITS + 1;
  localparam int CSHIFT    = 24 - FRAC_BITS;
  localparam int AW        = FRAC_BITS + 11;
  localparam int YW        = FRAC_BITS + 5;
  localparam int DIV_SHIFT = FRAC_BITS + 8;
  localparam int XW        = 2 * YW;
  // ceil(2^DIV_SHIFT / 15), exact for every quotient of this datapath.
  localparam logic [YW-1:0] DIV_RECIP =
    YW'(((64'd1 << DIV_SHIFT) + 64'd14) / 64'd15);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: clamp saturation and lightness to 0..4096, and lift the hue to a positive value.
  logic        v1_r, v1_nxt;
  logic [12:0] s1_s_r, s1_s_nxt;
  logic [12:0] s1_l_r, s1_l_nxt;
  logic [16:0] s1_hu_r, s1_hu_nxt;

  always_comb begin
    v1_nxt = accept;
    if (in_saturation < 14'sd0) begin
      s1_s_nxt = 13'd0;
    end else if (in_saturation > 14'(UNIT_IN)) begin
      s1_s_nxt = 13'(UNIT_IN);
    end else begin
      s1_s_nxt = in_saturation[12:0];
    end
    if (in_lightness < 14'sd0) begin
      s1_l_nxt = 13'd0;
    end else if (in_lightness > 14'(UNIT_IN)) begin
      s1_l_nxt = 13'(UNIT_IN);
    end else begin
      s1_l_nxt = in_lightness[12:0];
    end
    s1_hu_nxt = {in_hue[15], in_hue} + 17'(HUE_BIAS);
  end

  // Stage 2: one less the distance of twice the lightness from one, and the count of sectors.
  logic        v2_r;
  logic [12:0] s2_q_r, s2_q_nxt;
  logic [12:0] s2_s_r;
  logic [12:0] s2_l_r;
  logic [16:0] s2_hu_r;
  logic [6:0]  s2_k_r, s2_k_nxt;
  logic [13:0] twol;
  logic [12:0] dev;
  logic [23:0] kprod;

  always_comb begin
    twol = {s1_l_r, 1'b0};
    if (twol >= 14'(UNIT_IN)) begin
      dev = 13'(twol - 14'(UNIT_IN));
    end else begin
      dev = 13'(14'(UNIT_IN) - twol);
    end
    s2_q_nxt = 13'(UNIT_IN) - dev;
    // hue / 960 as (hue / 64) / 15.
    kprod    = 24'(s1_hu_r[16:6]) * 24'(HUE_DIV15_RECIP);
    s2_k_nxt = kprod[22:16];
  end

  // Stage 3: chroma, sector, position within the sector, and lightness in the fixed-point scale.
  logic          v3_r;
  logic [CW-1:0] s3_c_r, s3_c_nxt;
  sector_t       s3_sec_r, s3_sec_nxt;
  logic [9:0]    s3_f_r, s3_f_nxt;
  logic [CW-1:0] s3_lfx_r, s3_lfx_nxt;
  logic [25:0]   qs;
  logic [13:0]   kd6;
  logic [6:0]    sec_full;
  logic [16:0]   f_full;

  always_comb begin
    qs         = 26'(s2_q_r) * 26'(s2_s_r);
    s3_c_nxt   = qs[CSHIFT +: CW];
    kd6        = 14'(s2_k_r) * 14'(SEC_DIV6_RECIP);
    sec_full   = s2_k_r - 7'(7'(kd6[11:8]) * 7'd6);
    s3_sec_nxt = sector_t'(sec_full[2:0]);
    f_full     = s2_hu_r - 17'(17'(s2_k_r) * 17'(HUE_SECTOR));
    s3_f_nxt   = f_full[9:0];
    s3_lfx_nxt = CW'(s2_l_r) << (FRAC_BITS - 12);
  end

  // Stage 4: weighted chroma ready for the divide, and the offset m.
  logic          v4_r;
  logic [YW-1:0] s4_y_r, s4_y_nxt;
  logic [CW-1:0] s4_c_r;
  logic [CW-1:0] s4_m_r, s4_m_nxt;
  sector_t       s4_sec_r;
  logic [9:0]    t_w;
  logic [AW-1:0] ct;
  logic [CW-1:0] half;

  always_comb begin
    // Odd sectors fall, even sectors rise.
    t_w      = s3_sec_r[0] ? (10'(HUE_SECTOR) - s3_f_r) : s3_f_r;
    ct       = AW'(s3_c_r) * AW'(t_w);
    s4_y_nxt = YW'(ct[AW-1:6]);
    half     = s3_c_r >> 1;
    s4_m_nxt = (s3_lfx_r >= half) ? (s3_lfx_r - half) : '0;
  end

  // Stage 5: the remaining divide by 15.
  logic          v5_r;
  logic [CW-1:0] s5_x_r, s5_x_nxt;
  logic [CW-1:0] s5_c_r;
  logic [CW-1:0] s5_m_r;
  sector_t       s5_sec_r;
  logic [XW-1:0] yprod;

  always_comb begin
    yprod    = XW'(s4_y_r) * XW'(DIV_RECIP);
    s5_x_nxt = yprod[DIV_SHIFT +: CW];
  end

  // Stage 6: place chroma and x on the channels, add the offset m and scale to bytes.
  logic          out_valid_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r;
  logic [CW-1:0] rv, gv, bv;
  logic [7:0]    red_nxt, green_nxt, blue_nxt;

  always_comb begin
    unique case (s5_sec_r)
      SEC_RED_YELLOW: begin
        rv = s5_c_r; gv = s5_x_r; bv = '0;
      end
      SEC_YELLOW_GREEN: begin
        rv = s5_x_r; gv = s5_c_r; bv = '0;
      end
      SEC_GREEN_CYAN: begin
        rv = '0; gv = s5_c_r; bv = s5_x_r;
      end
      SEC_CYAN_BLUE: begin
        rv = '0; gv = s5_x_r; bv = s5_c_r;
      end
      SEC_BLUE_MAGENTA: begin
        rv = s5_x_r; gv = '0; bv = s5_c_r;
      end
      default: begin
        rv = s5_c_r; gv = '0; bv = s5_x_r;
      end
    endcase
  end

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
    .comp_val(rv), .offset(s5_m_r), .code(red_nxt)
  );
  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
    .comp_val(gv), .offset(s5_m_r), .code(green_nxt)
  );
  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
    .comp_val(bv), .offset(s5_m_r), .code(blue_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_s_r      <= s1_s_nxt;
    s1_l_r      <= s1_l_nxt;
    s1_hu_r     <= s1_hu_nxt;
    s2_q_r      <= s2_q_nxt;
    s2_s_r      <= s1_s_r;
    s2_l_r      <= s1_l_r;
    s2_hu_r     <= s1_hu_r;
    s2_k_r      <= s2_k_nxt;
    s3_c_r      <= s3_c_nxt;
    s3_sec_r    <= s3_sec_nxt;
    s3_f_r      <= s3_f_nxt;
    s3_lfx_r    <= s3_lfx_nxt;
    s4_y_r      <= s4_y_nxt;
    s4_c_r      <= s3_c_r;
    s4_m_r      <= s4_m_nxt;
    s4_sec_r    <= s3_sec_r;
    s5_x_r      <= s5_x_nxt;
    s5_c_r      <= s4_c_r;
    s5_m_r      <= s4_m_r;
    s5_sec_r    <= s4_sec_r;
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // Every accepted word appears on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("accepted word did not appear after six cycles");

  // No strobe without a matching accepted word.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 6))
    else $error("result strobe without an accepted word");

  // Zero or negative saturation gives a grey: all three channels equal.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_saturation <= 14'sd0) |->
      ##6 (out_red == out_green && out_green == out_blue))
    else $error("unsaturated word did not give a grey");

endmodule
`default_nettype wire

>>> src/hsl_chan.sv
`default_nettype none
module hsl_chan
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic [FRAC_BITS:0] comp_val,
  input  wire logic [FRAC_BITS:0] offset,
  output logic      [7:0]         code
);

  localparam int SW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 10;

  logic [SW-1:0] sum;
  logic [PW-1:0] scaled;
  logic [9:0]    whole;

  assign sum    = SW'(comp_val) + SW'(offset);
  // Times 255 as times 256 less one copy.
  assign scaled = {sum, 8'b0} - PW'(sum);
  assign whole  = scaled[PW-1:FRAC_BITS];
  assign code   = (whole > 10'(BYTE_MAX)) ? 8'(BYTE_MAX) : whole[7:0];

endmodule
`default_nettype wire
